// ----- src/bpa_pkg.sv -----
// Package for the bitmap page allocator.
// Holds field widths, request and status codes, the sequencer state type
// and the bit-finder result struct. No dependencies.
package bpa_pkg;

  localparam int OFF_W     = 22;
  localparam int CNT_W     = 11;
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

  localparam logic [CNT_W-1:0] ALLOWED_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_REL_RD,
    ST_REL_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } find_t;

endpackage

// ----- src/bitmap_page_allocator.sv -----
// Bitmap page allocator: first-fit page acquire and release over a used-page
// bitmap in RAM. Depends on bpa_pkg, bpa_ram, bpa_div and bpa_find.
//
// Usage:
//   Input channel in_valid/in_stall carries in_kind (0 acquire, 1 release)
//   and in_release_offset. Result channel out_valid/out_stall carries
//   out_status, out_page_offset and out_used_pages, one result per
//   transaction. cfg_wr_en/cfg_wr_data writes the page limit (allowed_pages);
//   write it only while no transaction is in flight.
//   One transaction is worked on at a time; in_stall is high meanwhile.
//   Acquire: one 64-bit bitmap word is read per cycle; the lowest free page
//   under the limit is marked used, or status is FULL when none is free.
//   Release: a registered reciprocal multiply gives the page, then its word is
//   read and the bit cleared; a clear bit or out-of-range page gives BAD_RELEASE.
//   The result sits in an output register; a new transaction is taken while
//   it waits. If the receiver stalls, the next result holds the block in its
//   final cycle until the output register frees.
//   After reset the bitmap is cleared one word per cycle, with in_stall high;
//   the limit resets to 1024, the count to 0.
module bitmap_page_allocator #(
  parameter int BITMAP_WORDS = 16,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [bpa_pkg::OFF_W-1:0]     in_release_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]  out_status,
  output logic [bpa_pkg::OFF_W-1:0]     out_page_offset,
  output logic [bpa_pkg::CNT_W-1:0]     out_used_pages,
  input  logic                          cfg_wr_en,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_wr_data
);

  localparam int WADDR_W     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PAGE_W      = WADDR_W + bpa_pkg::BIT_IDX_W;
  localparam int LIM_W       = PAGE_W + 1;
  localparam int TOTAL_PAGES = BITMAP_WORDS * bpa_pkg::WORD_BITS;
  localparam int CMP_W       = (LIM_W > bpa_pkg::CNT_W) ? LIM_W : bpa_pkg::CNT_W;
  localparam int PB_W        = $clog2(PAGE_BYTES + 1);
  localparam int PROD_W      = PAGE_W + PB_W;
  localparam int MUL_W       = (PROD_W > bpa_pkg::OFF_W) ? PROD_W : bpa_pkg::OFF_W;

  bpa_pkg::state_t state_r, state_nxt;

  logic [WADDR_W-1:0]             clr_addr_r, clr_addr_nxt;
  logic [bpa_pkg::CNT_W-1:0]      allowed_r;
  logic [bpa_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [WADDR_W-1:0]             scan_addr_r, scan_addr_nxt;
  logic                           iss_r, iss_nxt;
  logic                           chk_valid_r, chk_valid_nxt;
  logic [WADDR_W-1:0]             chk_addr_r, chk_addr_nxt;
  logic [PAGE_W-1:0]              page_r, page_nxt;
  logic                           acq_r, acq_nxt;
  logic [bpa_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [bpa_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [bpa_pkg::OFF_W-1:0]      out_offset_r, out_offset_nxt;
  logic [bpa_pkg::CNT_W-1:0]      out_used_r, out_used_nxt;

  logic                           ram_wr_en;
  logic [WADDR_W-1:0]             ram_wr_addr;
  logic [bpa_pkg::WORD_BITS-1:0]  ram_wr_data;
  logic                           ram_rd_en;
  logic [WADDR_W-1:0]             ram_rd_addr;
  logic [bpa_pkg::WORD_BITS-1:0]  ram_rd_data;

  logic                           div_start;
  logic                           div_done;
  logic [bpa_pkg::OFF_W-1:0]      div_quo;

  bpa_pkg::find_t                 fr;
  logic [bpa_pkg::WORD_BITS-1:0]  set_word;

  logic                           in_accept;
  logic                           out_free;
  logic [LIM_W-1:0]               lim;
  logic                           scan_last;
  logic                           quo_ok;
  logic                           rel_bit;
  logic [bpa_pkg::WORD_BITS-1:0]  rel_word;
  logic [MUL_W-1:0]               prod;

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bpa_div #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_release_offset),
    .done     (div_done),
    .quotient (div_quo)
  );

  bpa_find #(
    .WADDR_W (WADDR_W),
    .LIM_W   (LIM_W)
  ) u_find (
    .word     (ram_rd_data),
    .word_idx (chk_addr_r),
    .lim      (lim),
    .res      (fr),
    .set_word (set_word)
  );

  assign in_stall  = (state_r != bpa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign lim = (CMP_W'(allowed_r) > CMP_W'(TOTAL_PAGES)) ? LIM_W'(TOTAL_PAGES)
                                                         : LIM_W'(allowed_r);
  assign scan_last = (scan_addr_r == WADDR_W'(BITMAP_WORDS - 1)) ||
                     ((LIM_W'({scan_addr_r, 6'b0}) + LIM_W'(64)) >= lim);
  assign quo_ok    = (div_quo < bpa_pkg::OFF_W'(TOTAL_PAGES));
  assign rel_bit   = ram_rd_data[page_r[bpa_pkg::BIT_IDX_W-1:0]];
  assign rel_word  = ram_rd_data & ~(64'(1) << page_r[bpa_pkg::BIT_IDX_W-1:0]);
  assign prod      = MUL_W'(page_r) * MUL_W'(PAGE_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::ST_CLEAR: begin
        if (clr_addr_r == WADDR_W'(BITMAP_WORDS - 1)) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_kind == bpa_pkg::KIND_ACQUIRE) ? bpa_pkg::ST_SCAN
                                                         : bpa_pkg::ST_DIV;
        end
      end
      bpa_pkg::ST_SCAN: begin
        if ((chk_valid_r && fr.found) || (!iss_r && !chk_valid_r)) begin
          state_nxt = bpa_pkg::ST_RESP;
        end
      end
      bpa_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = quo_ok ? bpa_pkg::ST_REL_RD : bpa_pkg::ST_RESP;
        end
      end
      bpa_pkg::ST_REL_RD: begin
        state_nxt = bpa_pkg::ST_REL_CHK;
      end
      bpa_pkg::ST_REL_CHK: begin
        state_nxt = bpa_pkg::ST_RESP;
      end
      bpa_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::ST_CLEAR;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_addr_nxt   = clr_addr_r;
    count_nxt      = count_r;
    scan_addr_nxt  = scan_addr_r;
    iss_nxt        = iss_r;
    chk_valid_nxt  = chk_valid_r;
    chk_addr_nxt   = chk_addr_r;
    page_nxt       = page_r;
    acq_nxt        = acq_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_used_nxt   = out_used_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = chk_addr_r;
    ram_wr_data    = set_word;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_addr_r;
    div_start      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bpa_pkg::ST_CLEAR: begin
        ram_wr_en    = 1'b1;
        ram_wr_addr  = clr_addr_r;
        ram_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + WADDR_W'(1);
      end
      bpa_pkg::ST_IDLE: begin
        if (in_accept) begin
          acq_nxt = (in_kind == bpa_pkg::KIND_ACQUIRE);
          if (in_kind == bpa_pkg::KIND_ACQUIRE) begin
            scan_addr_nxt = '0;
            iss_nxt       = (lim != '0);
            chk_valid_nxt = 1'b0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      bpa_pkg::ST_SCAN: begin
        ram_rd_en     = iss_r;
        ram_rd_addr   = scan_addr_r;
        chk_valid_nxt = iss_r;
        chk_addr_nxt  = scan_addr_r;
        if (iss_r) begin
          if (scan_last) begin
            iss_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + WADDR_W'(1);
          end
        end
        if (chk_valid_r && fr.found) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = chk_addr_r;
          ram_wr_data = set_word;
          page_nxt    = {chk_addr_r, fr.bit_idx};
          count_nxt   = count_r + bpa_pkg::CNT_W'(1);
          status_nxt  = bpa_pkg::STATUS_DONE;
        end else if (!iss_r && !chk_valid_r) begin
          status_nxt = bpa_pkg::STATUS_FULL;
        end
      end
      bpa_pkg::ST_DIV: begin
        if (div_done) begin
          if (quo_ok) begin
            page_nxt = div_quo[PAGE_W-1:0];
          end else begin
            status_nxt = bpa_pkg::STATUS_BAD_RELEASE;
          end
        end
      end
      bpa_pkg::ST_REL_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = page_r[PAGE_W-1:bpa_pkg::BIT_IDX_W];
      end
      bpa_pkg::ST_REL_CHK: begin
        if (rel_bit) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = page_r[PAGE_W-1:bpa_pkg::BIT_IDX_W];
          ram_wr_data = rel_word;
          count_nxt   = count_r - bpa_pkg::CNT_W'(1);
          status_nxt  = bpa_pkg::STATUS_DONE;
        end else begin
          status_nxt = bpa_pkg::STATUS_BAD_RELEASE;
        end
      end
      bpa_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_used_nxt   = count_r;
          if (acq_r && (status_r == bpa_pkg::STATUS_DONE)) begin
            out_offset_nxt = prod[bpa_pkg::OFF_W-1:0];
          end else begin
            out_offset_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      allowed_r   <= bpa_pkg::ALLOWED_RESET;
      count_r     <= '0;
      iss_r       <= 1'b0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        allowed_r <= cfg_wr_data;
      end
    end
    scan_addr_r  <= scan_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    page_r       <= page_nxt;
    acq_r        <= acq_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_offset = out_offset_r;
  assign out_used_pages  = out_used_r;

endmodule

// ----- src/bpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
// One write port, one read port. No dependencies.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bpa_div.sv -----
// Divider of a byte offset by the constant page size, done as one
// multiply by the rounded-up reciprocal; the result is registered. Depends on bpa_pkg.
module bpa_div #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bpa_pkg::OFF_W-1:0]  dividend,
  output logic                       done,
  output logic [bpa_pkg::OFF_W-1:0]  quotient
);

  // exact for every OFF_W-bit dividend: reciprocal error stays below 1/PAGE_BYTES
  localparam int SH                = bpa_pkg::OFF_W + $clog2(PAGE_BYTES);
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) /
                                      64'(PAGE_BYTES);
  localparam int RCP_W             = bpa_pkg::OFF_W + 1;
  localparam int PRD_W             = bpa_pkg::OFF_W + RCP_W;

  logic [RCP_W-1:0]          rcp;
  logic [PRD_W-1:0]          prod;
  logic [PRD_W-1:0]          shifted;
  logic [bpa_pkg::OFF_W-1:0] quo_r, quo_nxt;
  logic                      done_r, done_nxt;

  always_comb begin
    rcp      = RCP_W'(RECIP);
    prod     = {{RCP_W{1'b0}}, dividend} * {{bpa_pkg::OFF_W{1'b0}}, rcp};
    shifted  = prod >> SH;
    quo_nxt  = quo_r;
    done_nxt = start;
    if (start) begin
      quo_nxt = shifted[bpa_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/bpa_find.sv -----
// Lowest free page finder for one 64-bit bitmap word under the page limit.
// Masks pages at or above the limit, isolates the lowest zero. Depends on bpa_pkg.
module bpa_find #(
  parameter int WADDR_W = 4,
  parameter int LIM_W   = 11
) (
  input  logic [bpa_pkg::WORD_BITS-1:0] word,
  input  logic [WADDR_W-1:0]            word_idx,
  input  logic [LIM_W-1:0]              lim,
  output bpa_pkg::find_t                res,
  output logic [bpa_pkg::WORD_BITS-1:0] set_word
);

  logic [LIM_W-1:0]              base;
  logic [LIM_W-1:0]              rem;
  logic [bpa_pkg::WORD_BITS-1:0] mask;
  logic [bpa_pkg::WORD_BITS-1:0] avail;
  logic [bpa_pkg::WORD_BITS-1:0] iso;
  logic [bpa_pkg::BIT_IDX_W-1:0] idx;

  always_comb begin
    base = LIM_W'({word_idx, 6'b0});
    rem  = lim - base;
    if (|rem[LIM_W-1:bpa_pkg::BIT_IDX_W]) begin
      mask = '1;
    end else begin
      mask = (64'(1) << rem[bpa_pkg::BIT_IDX_W-1:0]) - 64'(1);
    end
    avail = ~word & mask;
    iso   = avail & (~avail + 64'(1));
    idx   = '0;
    for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
      if (iso[b]) begin
        idx = idx | bpa_pkg::BIT_IDX_W'(b);
      end
    end
    res.found   = |avail;
    res.bit_idx = idx;
    set_word    = word | iso;
  end

endmodule
